@@ src/seedsequence_pcg64_first_draw_assert.svh @@
// assertion macros for the seeded pcg64 first-draw block
// included by the rtl modules that carry checks; no other dependencies
`ifndef SEEDSEQUENCE_PCG64_FIRST_DRAW_ASSERT_SVH
`define SEEDSEQUENCE_PCG64_FIRST_DRAW_ASSERT_SVH
`ifndef SYNTHESIS
`define SSPCG_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("sspcg assertion failed");
`define SSPCG_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("sspcg reset assertion failed");
`else
`define SSPCG_ASSERT(lbl, clk, rstn, prop)
`define SSPCG_ASSERT_RST(lbl, clk, prop)
`endif
`endif

@@ src/sspcg_pkg.sv @@
// shared types, constants and hash helpers for the seeded pcg64 first-draw block
// no dependencies
package sspcg_pkg;

    typedef logic [31:0]       t_w32;
    typedef logic [3:0][31:0]  t_pool;
    typedef logic [127:0]      t_u128;

    localparam t_w32 HASH_INIT_A = 32'h43b0d7e5;
    localparam t_w32 HASH_MULT_A = 32'h931e8875;
    localparam t_w32 HASH_INIT_B = 32'h8b51f9dd;
    localparam t_w32 HASH_MULT_B = 32'h58f38ded;
    localparam t_w32 MIX_LEFT    = 32'hca01f9dd;
    localparam t_w32 MIX_RIGHT   = 32'h4973f715;
    localparam t_u128 LCG_MULT   = {64'd2549297995355413924, 64'd4865540595714422341};

    // hash constant after k updates
    function automatic t_w32 hc_at(input t_w32 init, input t_w32 mult, input int k);
        t_w32 h;
        h = init;
        for (int i = 0; i < k; i++) begin
            h = h * mult;
        end
        return h;
    endfunction

    function automatic t_w32 xs16(input t_w32 t);
        return t ^ (t >> 16);
    endfunction

    // destination word of the j-th mix in row s
    function automatic logic [1:0] row_dst(input int s, input int j);
        return (j < s) ? 2'(j) : 2'(j + 1);
    endfunction

    function automatic t_w32 lcg_limb(input int j);
        return LCG_MULT[32*j +: 32];
    endfunction

endpackage

@@ src/seedsequence_pcg64_first_draw.sv @@
// a request passes the input hash, the mix rows, the output hash, the lcg steps and the output register
// throughput: one request per cycle; a held result stalls the whole pipeline in place
// the path is set by the pool cross-mix (two stages per row) and two 3-stage lcg steps
// reset: synchronous, active low; clears the valid bits only, data registers keep values
// depends on sspcg_pkg, sspcg_mix_row, sspcg_lcg and the assertion macro header
module seedsequence_pcg64_first_draw (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_seed,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_random_word,
    output logic [52:0] o_uniform_fraction
);
    import sspcg_pkg::*;
`include "seedsequence_pcg64_first_draw_assert.svh"

    logic   adv;
    logic   r_v1, r_vb, r_vw, r_vo;
    t_w32   r_p1 [4];
    t_pool  ent, pool1;
    t_pool  pool_r [5];
    logic   vld_r [5];
    t_w32   r_st [8];
    logic [63:0] w [4];
    t_u128  init, inc;
    t_u128  r_s2, r_inc;
    logic   vld_l0, vld_l1;
    t_u128  st_l0, st_l1;
    logic [63:0] folded;
    logic [5:0]  rot;
    logic [127:0] dbl;
    logic [63:0] r_word;

    assign adv     = !r_vo || i_ready;
    assign o_ready = adv;

    assign ent = {32'd0, 32'd0, i_seed[63:32], i_seed[31:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_vb <= 1'b0;
            r_vw <= 1'b0;
            r_vo <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_vb <= vld_r[4];
            r_vw <= r_vb;
            r_vo <= vld_l1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 4; i++) begin
                r_p1[i] <= (ent[i] ^ hc_at(HASH_INIT_A, HASH_MULT_A, i))
                           * hc_at(HASH_INIT_A, HASH_MULT_A, i + 1);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            pool1[i] = xs16(r_p1[i]);
        end
    end

    assign pool_r[0] = pool1;
    assign vld_r[0]  = r_v1;

    for (genvar g = 0; g < 4; g++) begin : g_row
        sspcg_mix_row #(
            .ROW(g)
        ) u_row (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (adv),
            .i_vld  (vld_r[g]),
            .i_pool (pool_r[g]),
            .o_vld  (vld_r[g+1]),
            .o_pool (pool_r[g+1])
        );
    end

    // eight output hashes and the first lcg step folded with the add of the initial state
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < 8; i++) begin
                r_st[i] <= (pool_r[4][i % 4] ^ hc_at(HASH_INIT_B, HASH_MULT_B, i))
                           * hc_at(HASH_INIT_B, HASH_MULT_B, i + 1);
            end
            r_s2  <= inc + init;
            r_inc <= inc;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w[k] = {xs16(r_st[2*k+1]), xs16(r_st[2*k])};
        end
        init = {w[0], w[1]};
        inc  = {w[2][62:0], w[3], 1'b1};
    end

    sspcg_lcg u_lcg0 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (r_vw),
        .i_state(r_s2),
        .i_inc  (r_inc),
        .o_vld  (vld_l0),
        .o_state(st_l0)
    );

    // increment is a per-item constant; the r_inc_d registers carry it alongside the first step to the second
    t_u128 r_inc_d [3];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_inc_d[0] <= r_inc;
            r_inc_d[1] <= r_inc_d[0];
            r_inc_d[2] <= r_inc_d[1];
        end
    end

    sspcg_lcg u_lcg1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (adv),
        .i_vld  (vld_l0),
        .i_state(st_l0),
        .i_inc  (r_inc_d[2]),
        .o_vld  (vld_l1),
        .o_state(st_l1)
    );

    // xsl-rr output: fold the halves, rotate right by the top six state bits
    assign folded = st_l1[127:64] ^ st_l1[63:0];
    assign rot    = st_l1[127:122];
    assign dbl    = {folded, folded} >> rot;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_word <= dbl[63:0];
        end
    end

    assign o_valid            = r_vo;
    assign o_random_word      = r_word;
    assign o_uniform_fraction = r_word[63:11];

    `SSPCG_ASSERT_RST(a_reset_clears_out, i_clk, !i_rst_n |=> !o_valid)
    `SSPCG_ASSERT(a_stall_only_when_held, i_clk, i_rst_n, !o_ready |-> (o_valid && !i_ready))
    `SSPCG_ASSERT(a_out_follows_lcg, i_clk, i_rst_n, adv |=> (r_vo == $past(vld_l1)))
    `SSPCG_ASSERT(a_zero_rotation, i_clk, i_rst_n,
        (adv && rot == 6'd0) |=> (r_word == $past(folded)))

endmodule

@@ src/sspcg_mix_row.sv @@
// one row of the pool cross-mix: hash of the source word, then mix into the other three
// two register stages; uses sspcg_pkg
module sspcg_mix_row #(
    parameter int ROW = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  sspcg_pkg::t_pool i_pool,
    output logic             o_vld,
    output sspcg_pkg::t_pool o_pool
);
    import sspcg_pkg::*;

    localparam int BASE = 4 + 3 * ROW;

    logic       r_vld_a, r_vld_b;
    t_w32       r_h  [3];
    t_w32       r_la [3];
    t_w32       r_rb [3];
    t_w32       r_lb [3];
    t_w32       r_ps_a, r_ps_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else if (i_en) begin
            r_vld_a <= i_vld;
            r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_h[j]  <= (i_pool[2'(ROW)] ^ hc_at(HASH_INIT_A, HASH_MULT_A, BASE + j))
                           * hc_at(HASH_INIT_A, HASH_MULT_A, BASE + j + 1);
                r_la[j] <= MIX_LEFT * i_pool[row_dst(ROW, j)];
                r_rb[j] <= MIX_RIGHT * xs16(r_h[j]);
                r_lb[j] <= r_la[j];
            end
            r_ps_a <= i_pool[2'(ROW)];
            r_ps_b <= r_ps_a;
        end
    end

    always_comb begin
        o_pool         = '0;
        o_pool[2'(ROW)] = r_ps_b;
        for (int j = 0; j < 3; j++) begin
            o_pool[row_dst(ROW, j)] = xs16(r_lb[j] - r_rb[j]);
        end
    end

    assign o_vld = r_vld_b;

endmodule

@@ src/sspcg_lcg.sv @@
// one 128-bit lcg step, state * multiplier + increment, over 32-bit limb products
// three register stages; uses sspcg_pkg
module sspcg_lcg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  sspcg_pkg::t_u128 i_state,
    input  sspcg_pkg::t_u128 i_inc,
    output logic             o_vld,
    output sspcg_pkg::t_u128 o_state
);
    import sspcg_pkg::*;

    logic        r_vld_p, r_vld_c, r_vld_s;
    logic [63:0] r_c0;
    logic [63:0] r_c1 [2];
    logic [63:0] r_c2 [3];
    logic [31:0] r_c3 [4];
    logic [63:0] r_s0;
    logic [64:0] r_s1;
    logic [65:0] r_s2;
    logic [31:0] r_s3;
    t_u128       r_inc_p, r_inc_c;
    t_u128       r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_p <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_s <= 1'b0;
        end else if (i_en) begin
            r_vld_p <= i_vld;
            r_vld_c <= r_vld_p;
            r_vld_s <= r_vld_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // limb products, grouped by column; the top column only keeps its low half
            r_c0 <= 64'(i_state[31:0]) * 64'(lcg_limb(0));
            for (int k = 0; k < 2; k++) begin
                r_c1[k] <= 64'(i_state[32*k +: 32]) * 64'(lcg_limb(1 - k));
            end
            for (int k = 0; k < 3; k++) begin
                r_c2[k] <= 64'(i_state[32*k +: 32]) * 64'(lcg_limb(2 - k));
            end
            for (int k = 0; k < 4; k++) begin
                r_c3[k] <= i_state[32*k +: 32] * lcg_limb(3 - k);
            end
            r_inc_p <= i_inc;

            r_s0    <= r_c0;
            r_s1    <= 65'(r_c1[0]) + 65'(r_c1[1]);
            r_s2    <= 66'(r_c2[0]) + 66'(r_c2[1]) + 66'(r_c2[2]);
            r_s3    <= r_c3[0] + r_c3[1] + r_c3[2] + r_c3[3];
            r_inc_c <= r_inc_p;

            r_state <= 128'(r_s0) + (128'(r_s1) << 32) + (128'(r_s2) << 64)
                       + {r_s3, 96'd0} + r_inc_c;
        end
    end

    assign o_vld   = r_vld_s;
    assign o_state = r_state;

endmodule

@@ tb/sv/testbench.sv @@
// testbench for the seeded pcg64 first-draw block: random and directed seeds,
// results predicted in the scoreboard class and checked in order
// depends on the rtl of seedsequence_pcg64_first_draw and sspcg_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    class draw_scoreboard;
        logic [63:0] pending_words[$];
        int          n_fail;
        int          n_checked;

        function logic [31:0] hash32(input logic [31:0] val,
                                     inout logic [31:0] hc,
                                     input logic [31:0] mult);
            logic [31:0] t;
            t = val ^ hc;
            hc = hc * mult;
            t = t * hc;
            return t ^ (t >> 16);
        endfunction

        function logic [63:0] first_draw(input logic [63:0] seed);
            logic [31:0]  ent[4];
            logic [31:0]  pool[4];
            logic [31:0]  st[8];
            logic [31:0]  hc;
            logic [31:0]  m;
            logic [63:0]  w[4];
            logic [127:0] inc;
            logic [127:0] s;
            logic [127:0] mult;
            logic [63:0]  folded;
            int           rot;
            ent[0] = seed[31:0];
            ent[1] = seed[63:32];
            ent[2] = '0;
            ent[3] = '0;
            hc = 32'h43b0d7e5;
            for (int i = 0; i < 4; i++) pool[i] = hash32(ent[i], hc, 32'h931e8875);
            for (int a = 0; a < 4; a++)
                for (int d = 0; d < 4; d++)
                    if (a != d) begin
                        m = hash32(pool[a], hc, 32'h931e8875);
                        m = 32'hca01f9dd * pool[d] - 32'h4973f715 * m;
                        pool[d] = m ^ (m >> 16);
                    end
            hc = 32'h8b51f9dd;
            for (int i = 0; i < 8; i++) st[i] = hash32(pool[i & 3], hc, 32'h58f38ded);
            for (int i = 0; i < 4; i++) w[i] = {st[2*i+1], st[2*i]};
            mult = {64'd2549297995355413924, 64'd4865540595714422341};
            inc = ({w[2], w[3]} << 1) | 128'd1;
            s = inc;
            s = s + {w[0], w[1]};
            s = s * mult + inc;
            s = s * mult + inc;
            folded = s[127:64] ^ s[63:0];
            rot = int'(s[127:122]);
            return (folded >> rot) | (folded << ((64 - rot) & 63));
        endfunction

        function void note_seed(input logic [63:0] seed);
            pending_words = {pending_words, first_draw(seed)};
        endfunction

        function void check_draw(input logic [63:0] word, input logic [52:0] frac);
            logic [63:0] exp_word;
            n_checked++;
            if (pending_words.size() == 0) begin
                $display("%t unexpected result: got word %h", $realtime, word);
                n_fail++;
                return;
            end
            exp_word = pending_words.pop_front();
            if (word !== exp_word) begin
                $display("%t random_word: expected %h, got %h", $realtime, exp_word, word);
                n_fail++;
            end
            if (frac !== exp_word[63:11]) begin
                $display("%t uniform_fraction: expected %h, got %h",
                         $realtime, exp_word[63:11], frac);
                n_fail++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [63:0] i_seed = '0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [63:0] o_random_word;
    logic [52:0] o_uniform_fraction;

    draw_scoreboard sb = new();
    int  cycles = 0;
    bit  sending_done = 0;
    bit  no_gaps = 0;
    int  n_seeds = 0;

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    seedsequence_pcg64_first_draw i_dut (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("testbench NOT OK");
            $finish;
        end
        if (i_rst_n && i_valid && o_ready) sb.note_seed(i_seed);
        if (i_rst_n && o_valid && i_ready) sb.check_draw(o_random_word, o_uniform_fraction);
    end

    // valid stays high after an accepted request until the next call decides
    task automatic send_seed(input logic [63:0] seed);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1;
        i_seed <= seed;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        n_seeds++;
    endtask

    // send back-to-back requests where no gap is drawn
    task automatic send_burst(input int n);
        for (int k = 0; k < n; k++) begin
            i_valid <= 1;
            i_seed <= {$urandom, $urandom};
            do @(posedge i_clk); while (!o_ready);
            n_seeds++;
            @(negedge i_clk);
        end
    endtask

    // result side: ready idles at random, with stretches always ready
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = (cycles % 3000 < 800) ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                i_ready <= 0;
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1;
        end
    end

    initial begin
        logic [63:0] seed;
        int wait_cycles;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_seed(64'd0);
        send_seed(64'hffff_ffff_ffff_ffff);
        send_seed(64'h0000_0000_ffff_ffff);
        send_seed(64'hffff_ffff_0000_0000);
        send_seed(64'd1);
        send_seed(64'h8000_0000_0000_0000);
        send_seed(64'h0000_0001_0000_0000);
        send_seed(64'h5555_5555_5555_5555);
        send_seed(64'haaaa_aaaa_aaaa_aaaa);
        for (int b = 0; b < 64; b++) send_seed(64'd1 << b);
        for (int k = 0; k < 1100; k++) begin
            case ($urandom_range(0, 5))
                0: seed = {32'd0, $urandom};
                1: seed = 64'($urandom_range(0, 255));
                default: seed = {$urandom, $urandom};
            endcase
            send_seed(seed);
            if (k % 200 == 0) send_burst(20);
        end
        no_gaps = 1;
        send_burst(40);
        i_valid <= 0;
        wait_cycles = 0;
        while (sb.pending_words.size() != 0 && wait_cycles < 5000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        $display("sent %0d seeds (edges, single bits, half-zero and random), %0d results checked",
                 n_seeds, sb.n_checked);
        if (sb.n_fail == 0 && sb.pending_words.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule
